@@ src/lpa_pkg.sv @@
`timescale 1ns / 1ps
package lpa_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int ER_W       = 24;
    localparam int OR_W       = 26;
    localparam int ALT_W      = 20;
    localparam int ANG_W      = 16;
    localparam int COORD_W    = 27;
    localparam int R_W        = 25;
    localparam int X_W        = 26;
    localparam int H_W        = 25;
    localparam int CFG_DATA_W = 26;

    localparam logic [ER_W-1:0] EARTH_RESET = 24'd6371000;
    localparam logic [OR_W-1:0] ORBIT_RESET = 26'd42164000;

    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    localparam int HORNER_STEPS = 7;
    // phase fold, theta, theta squared, three per horner step, final product, rounding
    localparam int SINE_LAT = 3 + 3 * HORNER_STEPS + 2;

    typedef enum logic [0:0] {
        REG_EARTH_RADIUS,
        REG_ORBIT_RADIUS
    } cfg_reg_t;

    typedef struct packed {
        logic [X_W-1:0] x;
        logic [H_W-1:0] h;
        logic           no_limb;
    } geom_t;

    typedef struct packed {
        logic [30:0] th;
        logic [31:0] th2;
        logic        neg;
    } sine_carry_t;

    function automatic logic [7:0] horner_div(input int k);
        logic [7:0] d;
        case (k)
            0:       d = 8'd210;
            1:       d = 8'd156;
            2:       d = 8'd110;
            3:       d = 8'd72;
            4:       d = 8'd42;
            5:       d = 8'd20;
            default: d = 8'd6;
        endcase
        return d;
    endfunction

endpackage

@@ src/lpa_delay.sv @@
`timescale 1ns / 1ps
module lpa_delay
#(
    parameter int W     = 1,
    parameter int DEPTH = 1
)
(
    input  logic         clk,
    input  logic         adv,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    generate
        if (DEPTH == 0)
        begin : g_none
            assign q = d;
        end
        else
        begin : g_line
            logic [W-1:0] tap_reg [0:DEPTH-1];
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    tap_reg[0] <= d;
                end
            end
            for (genvar i = 1; i < DEPTH; i++)
            begin : g_tap
                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        tap_reg[i] <= tap_reg[i-1];
                    end
                end
            end
            assign q = tap_reg[DEPTH-1];
        end
    endgenerate

endmodule

@@ src/lpa_geom.sv @@
`timescale 1ns / 1ps
module lpa_geom
    import lpa_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic            clk,
    input  logic            adv,
    input  logic [R_W-1:0]  radius,
    input  logic [OR_W-1:0] orbit_radius,
    output geom_t           geom
);

    localparam int F  = FRAC_BITS;
    localparam int SW = 2 * F + 2;
    localparam int RW = F + 1;
    localparam logic [SW-1:0] ONE_SQ = SW'(1) << (2 * F);

    // restoring divider, one quotient bit per stage
    logic [OR_W-1:0] rem_reg [0:F];
    logic [F-1:0]    quo_reg [0:F];
    logic [R_W-1:0]  rad_reg [0:F];
    logic            nl_reg  [0:F];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= OR_W'(radius);
            quo_reg[0] <= '0;
            rad_reg[0] <= radius;
            nl_reg[0]  <= ({1'b0, radius} >= orbit_radius);
        end
    end

    generate
        for (genvar i = 0; i < F; i++)
        begin : g_div
            logic [OR_W:0] dbl;
            logic          take;
            always_comb
            begin
                dbl  = {rem_reg[i], 1'b0};
                take = (dbl >= {1'b0, orbit_radius});
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[i+1] <= take ? OR_W'(dbl - {1'b0, orbit_radius}) : OR_W'(dbl);
                    quo_reg[i+1] <= {quo_reg[i][F-2:0], take};
                    rad_reg[i+1] <= rad_reg[i];
                    nl_reg[i+1]  <= nl_reg[i];
                end
            end
        end
    endgenerate

    // square root, one result bit per stage
    logic [SW-1:0]  srem_reg  [0:F+1];
    logic [RW-1:0]  sroot_reg [0:F+1];
    logic [F-1:0]   scb_reg   [0:F+1];
    logic [R_W-1:0] srad_reg  [0:F+1];
    logic           snl_reg   [0:F+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            srem_reg[0]  <= ONE_SQ - (SW'(quo_reg[F]) * SW'(quo_reg[F]));
            sroot_reg[0] <= '0;
            scb_reg[0]   <= quo_reg[F];
            srad_reg[0]  <= rad_reg[F];
            snl_reg[0]   <= nl_reg[F];
        end
    end

    generate
        for (genvar k = 0; k <= F; k++)
        begin : g_sqrt
            localparam int B = F - k;
            logic [SW-1:0] trial;
            logic          ge;
            always_comb
            begin
                trial = (SW'(sroot_reg[k]) << (B + 1)) + (SW'(1) << (2 * B));
                ge    = (srem_reg[k] >= trial);
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    srem_reg[k+1]  <= ge ? (srem_reg[k] - trial) : srem_reg[k];
                    sroot_reg[k+1] <= ge ? (sroot_reg[k] | (RW'(1) << B)) : sroot_reg[k];
                    scb_reg[k+1]   <= scb_reg[k];
                    srad_reg[k+1]  <= srad_reg[k];
                    snl_reg[k+1]   <= snl_reg[k];
                end
            end
        end
    endgenerate

    logic [R_W+F-1:0] px_reg;
    logic [R_W+F:0]   ph_reg;
    logic             pnl_reg;
    geom_t            geom_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg  <= (R_W+F)'(srad_reg[F+1]) * (R_W+F)'(scb_reg[F+1]);
            ph_reg  <= (R_W+F+1)'(srad_reg[F+1]) * (R_W+F+1)'(sroot_reg[F+1]);
            pnl_reg <= snl_reg[F+1];
            geom_reg.x       <= X_W'(({1'b0, px_reg} + (R_W+F+1)'(1 << (F - 1))) >> F);
            geom_reg.h       <= H_W'(({1'b0, ph_reg} + (R_W+F+2)'(1 << (F - 1))) >> F);
            geom_reg.no_limb <= pnl_reg;
        end
    end

    assign geom = geom_reg;

endmodule

@@ src/lpa_sine.sv @@
`timescale 1ns / 1ps
module lpa_sine
    import lpa_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 adv,
    input  logic [31:0]          phase,
    output logic [FRAC_BITS+1:0] mag,
    output logic                 neg
);

    localparam int F  = FRAC_BITS;
    localparam int SH = 30 - F;
    localparam logic [31:0] HALF_Q = (SH == 0) ? 32'd0 : (32'd1 << (SH - 1));

    logic [30:0] t_reg;
    logic        n1_reg;
    logic [30:0] th_reg;
    logic        n2_reg;
    logic [61:0] thp;
    logic [61:0] th2p;

    // fold odd quadrants onto the first
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg  <= phase[30] ? (Q30_ONE - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
            n1_reg <= phase[31];
            th_reg <= thp[60:30];
            n2_reg <= n1_reg;
        end
    end

    assign thp  = 62'(t_reg) * 62'(HALF_PI_Q30);
    assign th2p = 62'(th_reg) * 62'(th_reg);

    sine_carry_t carry_reg [0:HORNER_STEPS];
    logic [30:0] s_reg     [0:HORNER_STEPS];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            carry_reg[0].th  <= th_reg;
            carry_reg[0].th2 <= th2p[61:30];
            carry_reg[0].neg <= n2_reg;
            s_reg[0]         <= Q30_ONE;
        end
    end

    // horner step: product, reciprocal estimate, one-step correction
    generate
        for (genvar k = 0; k < HORNER_STEPS; k++)
        begin : g_horner
            localparam logic [7:0]  DIV   = horner_div(k);
            localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / 64'(DIV));
            logic [31:0] va_reg;
            sine_carry_t ca_reg;
            logic [31:0] vb_reg;
            logic [31:0] qb_reg;
            sine_carry_t cc_reg;
            logic [63:0] sp;
            logic [63:0] qp;
            logic [31:0] rm;
            logic [31:0] qf;
            always_comb
            begin
                sp = 64'(carry_reg[k].th2) * 64'(s_reg[k]);
                qp = 64'(va_reg) * 64'(RECIP);
                rm = vb_reg - 32'(qb_reg * 32'(DIV));
                qf = qb_reg + 32'(rm >= 32'(DIV));
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    va_reg         <= sp[61:30];
                    ca_reg         <= carry_reg[k];
                    vb_reg         <= va_reg;
                    qb_reg         <= qp[63:32];
                    cc_reg         <= ca_reg;
                    s_reg[k+1]     <= Q30_ONE - qf[30:0];
                    carry_reg[k+1] <= cc_reg;
                end
            end
        end
    endgenerate

    logic [63:0]  mp;
    logic [30:0]  fm_reg;
    logic         nf_reg;
    logic [F+1:0] mag_reg;
    logic         neg_reg;

    assign mp = 64'(carry_reg[HORNER_STEPS].th) * 64'(s_reg[HORNER_STEPS]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fm_reg  <= mp[60:30];
            nf_reg  <= carry_reg[HORNER_STEPS].neg;
            mag_reg <= (F+2)'(({1'b0, fm_reg} + HALF_Q) >> SH);
            neg_reg <= nf_reg;
        end
    end

    assign mag = mag_reg;
    assign neg = neg_reg;

endmodule

@@ src/limb_point_from_altitude_angle.sv @@
`timescale 1ns / 1ps
// channel  | direction | handshake                   | payload
// item     | in        | item_valid / item_ready     | altitude, angle
// result   | out       | result_valid / result_ready | coord_x, coord_y, coord_z, no_limb
// config   | in        | cfg_we (no wait)            | cfg_index, cfg_data
//
// one item per cycle unless a result is held; the pipeline depth is set by the longer side:
// the bit-per-stage divider and square root on the radius side
// or the seven horner steps on the angle side
// reset clears the valid chain and loads the default radii
// a held result freezes the whole pipeline; item_ready drops only then
module limb_point_from_altitude_angle
    import lpa_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  logic [ALT_W-1:0]             altitude,
    input  logic [ANG_W-1:0]             angle,
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic signed [COORD_W-1:0]    coord_x,
    output logic signed [COORD_W-1:0]    coord_y,
    output logic signed [COORD_W-1:0]    coord_z,
    output logic                         no_limb,
    input  logic                         cfg_we,
    input  logic [0:0]                   cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data
);

    localparam int F        = FRAC_BITS;
    localparam int GEO_LAT  = 2 * F + 5;
    localparam int CORE_LAT = (GEO_LAT > SINE_LAT) ? GEO_LAT : SINE_LAT;
    localparam int LAT      = CORE_LAT + 2;
    localparam int DS       = CORE_LAT - SINE_LAT;
    localparam int DG       = CORE_LAT - GEO_LAT;
    localparam logic [31:0] AMASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);
    localparam int PW       = H_W + F + 2;

    logic [ER_W-1:0] earth_radius_reg;
    logic [OR_W-1:0] orbit_radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            earth_radius_reg <= EARTH_RESET;
            orbit_radius_reg <= ORBIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_EARTH_RADIUS: earth_radius_reg <= cfg_data[ER_W-1:0];
                REG_ORBIT_RADIUS: orbit_radius_reg <= cfg_data[OR_W-1:0];
            endcase
        end
    end

    logic           adv;
    logic [LAT-1:0] vld_reg;

    assign adv          = !vld_reg[LAT-1] || result_ready;
    assign item_ready   = adv;
    assign result_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], item_valid};
        end
    end

    logic [R_W-1:0] radius;
    logic [31:0]    ph_sin;
    logic [31:0]    ph_cos;
    logic [63:0]    ph_dly;
    geom_t          geom_raw;
    geom_t          geom_dly;

    assign radius = R_W'(earth_radius_reg) + R_W'(altitude);
    assign ph_sin = (32'(angle) & AMASK) << (32 - ANGLE_BITS);
    assign ph_cos = ph_sin + 32'h4000_0000;

    lpa_geom #(.FRAC_BITS(F)) u_geom (
        .clk          (clk),
        .adv          (adv),
        .radius       (radius),
        .orbit_radius (orbit_radius_reg),
        .geom         (geom_raw)
    );

    lpa_delay #(.W($bits(geom_t)), .DEPTH(DG)) u_geom_dly (
        .clk (clk),
        .adv (adv),
        .d   (geom_raw),
        .q   (geom_dly)
    );

    lpa_delay #(.W(64), .DEPTH(DS)) u_phase_dly (
        .clk (clk),
        .adv (adv),
        .d   ({ph_sin, ph_cos}),
        .q   (ph_dly)
    );

    logic [F+1:0] sin_mag;
    logic [F+1:0] cos_mag;
    logic         sin_neg;
    logic         cos_neg;

    lpa_sine #(.FRAC_BITS(F)) u_sin (
        .clk   (clk),
        .adv   (adv),
        .phase (ph_dly[63:32]),
        .mag   (sin_mag),
        .neg   (sin_neg)
    );

    lpa_sine #(.FRAC_BITS(F)) u_cos (
        .clk   (clk),
        .adv   (adv),
        .phase (ph_dly[31:0]),
        .mag   (cos_mag),
        .neg   (cos_neg)
    );

    logic [PW-1:0]    py_reg;
    logic [PW-1:0]    pz_reg;
    logic [X_W-1:0]   px_reg;
    logic             pnl_reg;
    logic             psn_reg;
    logic             pcn_reg;
    logic [COORD_W-1:0] ymag;
    logic [COORD_W-1:0] zmag;
    logic [COORD_W-1:0] coord_x_reg;
    logic [COORD_W-1:0] coord_y_reg;
    logic [COORD_W-1:0] coord_z_reg;
    logic               no_limb_reg;

    assign ymag = COORD_W'(({1'b0, py_reg} + (PW+1)'(1 << (F - 1))) >> F);
    assign zmag = COORD_W'(({1'b0, pz_reg} + (PW+1)'(1 << (F - 1))) >> F);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            py_reg  <= PW'(geom_dly.h) * PW'(sin_mag);
            pz_reg  <= PW'(geom_dly.h) * PW'(cos_mag);
            px_reg  <= geom_dly.x;
            pnl_reg <= geom_dly.no_limb;
            psn_reg <= sin_neg;
            pcn_reg <= cos_neg;
            // y takes the opposite sign of sin a
            coord_x_reg <= pnl_reg ? '0 : COORD_W'(px_reg);
            coord_y_reg <= pnl_reg ? '0 : (psn_reg ? ymag : (COORD_W'(0) - ymag));
            coord_z_reg <= pnl_reg ? '0 : (pcn_reg ? (COORD_W'(0) - zmag) : zmag);
            no_limb_reg <= pnl_reg;
        end
    end

    assign coord_x = coord_x_reg;
    assign coord_y = coord_y_reg;
    assign coord_z = coord_z_reg;
    assign no_limb = no_limb_reg;

endmodule

@@ src/lpa_checker.sv @@
`timescale 1ns / 1ps
module lpa_checker
    import lpa_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      item_ready,
    input logic                      result_valid,
    input logic                      result_ready,
    input logic signed [COORD_W-1:0] coord_x,
    input logic signed [COORD_W-1:0] coord_y,
    input logic signed [COORD_W-1:0] coord_z,
    input logic                      no_limb
);

    // a held result keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(coord_x)
            && $stable(coord_y) && $stable(coord_z) && $stable(no_limb))
        else $error("result changed while stalled");

    a_no_limb_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && no_limb |-> coord_x == '0 && coord_y == '0 && coord_z == '0)
        else $error("no_limb result with nonzero coordinates");

    a_x_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !no_limb |-> !coord_x[COORD_W-1])
        else $error("negative x coordinate");

    // an empty output stage never blocks new transfers
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> item_ready)
        else $error("input stalled with empty output");

endmodule

bind limb_point_from_altitude_angle lpa_checker u_lpa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .coord_x      (coord_x),
    .coord_y      (coord_y),
    .coord_z      (coord_z),
    .no_limb      (no_limb)
);
